// File: hdl/dlde_pkg.sv
// package for the depth-limited dfs engine: sizes, register indexes,
// sequencer states and the stack control struct; no dependencies
`default_nettype none

package dlde_pkg;

    localparam int NODES       = 4;
    localparam int STACK_DEPTH = 17;

    localparam int NODE_W  = 2;
    localparam int CNT_W   = 3;
    localparam int DEPTH_W = 6;
    localparam int COL_W   = $clog2(NODES);
    localparam int SP_W    = $clog2(STACK_DEPTH + 1);
    localparam int SI_W    = $clog2(STACK_DEPTH);
    localparam int CFG_W   = 6;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] CFG_NODE_COUNT  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_ROOT_NODE   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_GOAL_NODE   = 2'd2;
    localparam logic [IDX_W-1:0] CFG_DEPTH_LIMIT = 2'd3;

    localparam logic MODE_EDGE   = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_SCAN,
        ST_FINISH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic init;
        logic push;
        logic pop;
    } stk_ctl_t;

endpackage

`default_nettype wire

// File: hdl/dlde_stack.sv
// open-node stack of the dfs engine: init with one entry, push, pop
// depends on dlde_pkg
`default_nettype none

module dlde_stack (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire dlde_pkg::stk_ctl_t          ctl,
    input  wire logic [dlde_pkg::NODE_W-1:0] push_data,
    output logic      [dlde_pkg::NODE_W-1:0] top_data,
    output logic      [dlde_pkg::SP_W-1:0]   count
);

    logic [dlde_pkg::NODE_W-1:0] mem [dlde_pkg::STACK_DEPTH];
    logic [dlde_pkg::SP_W-1:0]   count_reg;
    logic [dlde_pkg::SP_W-1:0]   count_next;
    logic [dlde_pkg::SP_W-1:0]   top_ptr;
    logic                        has_room;

    assign has_room = count_reg < dlde_pkg::SP_W'(dlde_pkg::STACK_DEPTH);
    assign top_ptr  = count_reg - dlde_pkg::SP_W'(1);
    assign top_data = mem[top_ptr[dlde_pkg::SI_W-1:0]];
    assign count    = count_reg;

    always_comb begin
        count_next = count_reg;
        if (ctl.init) begin
            count_next = dlde_pkg::SP_W'(1);
        end else if (ctl.push && has_room) begin
            count_next = count_reg + dlde_pkg::SP_W'(1);
        end else if (ctl.pop) begin
            count_next = top_ptr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.init) begin
            mem[0] <= push_data;
        end else if (ctl.push && has_room) begin
            mem[count_reg[dlde_pkg::SI_W-1:0]] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: hdl/depth_limited_dfs_engine_unit.sv
// top level of the depth-limited dfs engine: adjacency matrix, depth table,
// sequencer and result register; depends on dlde_pkg and dlde_stack
//
//   channel   direction   tdata                     tuser / tlast
//   s_        in          from_node, to_node        tuser: mode
//   m_        out         visited_node              tuser: found, tlast: last
//   cfg_      in          register value            index 0..3
//
// an edge load is taken in the idle state; a search starts by loading the root into the stack,
// then each popped node passes through the pop state, a scan over the nodes in use and a finish
// state when it is expanded, then the emit state; the scan walks one column a cycle
// reset clears the matrix and the stack count and restores the register defaults
// s_tready is low for the whole search; a stalled result holds the sequencer
`default_nettype none

module depth_limited_dfs_engine_unit (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [7:0]                 s_tdata,   // from_node, to_node
    input  wire logic                       s_tuser,   // mode
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic      [7:0]                 m_tdata,   // visited_node
    output logic                            m_tlast,
    output logic                            m_tuser,   // found
    input  wire logic                       cfg_we,
    input  wire logic [dlde_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [dlde_pkg::CFG_W-1:0] cfg_data
);

    localparam int NW = dlde_pkg::NODE_W;
    localparam int DW = dlde_pkg::DEPTH_W;
    localparam int CW = dlde_pkg::CNT_W;
    localparam int LW = dlde_pkg::COL_W;

    logic [CW-1:0] node_count_reg;
    logic [NW-1:0] root_node_reg;
    logic [NW-1:0] goal_node_reg;
    logic [DW-1:0] depth_limit_reg;

    logic [dlde_pkg::NODES-1:0] edge_reg  [dlde_pkg::NODES];
    logic [DW-1:0]              depth_reg [dlde_pkg::NODES];

    dlde_pkg::state_t state_reg, state_next;
    logic [NW-1:0] node_reg, node_next;
    logic [LW-1:0] col_reg, col_next;
    logic [DW-1:0] lvl_reg, lvl_next;
    logic [NW-1:0] res_node_reg, res_node_next;
    logic          res_last_reg, res_last_next;
    logic          res_found_reg, res_found_next;
    logic          m_valid_reg, m_valid_next;
    logic [NW-1:0] m_node_reg, m_node_next;
    logic          m_last_reg, m_last_next;
    logic          m_found_reg, m_found_next;

    dlde_pkg::stk_ctl_t        stk_ctl;
    logic [NW-1:0]             stk_data;
    logic [NW-1:0]             stk_top;
    logic [dlde_pkg::SP_W-1:0] stk_count;
    logic [dlde_pkg::SP_W-1:0] cnt_after;

    logic          edge_set;
    logic          edge_clr;
    logic [NW-1:0] edge_row;
    logic [LW-1:0] edge_col;
    logic          depth_we;
    logic [NW-1:0] depth_addr;
    logic [DW-1:0] depth_val;

    logic [CW-1:0] n_eff;
    logic [NW-1:0] in_from;
    logic [NW-1:0] in_to;
    logic [DW:0]   next_lvl;

    assign n_eff = (node_count_reg > CW'(dlde_pkg::NODES)) ?
                   CW'(dlde_pkg::NODES) : node_count_reg;
    assign in_from   = s_tdata[NW-1:0];
    assign in_to     = s_tdata[2*NW-1:NW];
    assign next_lvl  = {1'b0, depth_reg[stk_top]} + (DW+1)'(1);
    assign cnt_after = stk_count - dlde_pkg::SP_W'(1);

    assign s_tready = (state_reg == dlde_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(8-NW){1'b0}}, m_node_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_found_reg;

    dlde_stack u_stack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (stk_ctl),
        .push_data (stk_data),
        .top_data  (stk_top),
        .count     (stk_count)
    );

    always_comb begin
        state_next     = state_reg;
        node_next      = node_reg;
        col_next       = col_reg;
        lvl_next       = lvl_reg;
        res_node_next  = res_node_reg;
        res_last_next  = res_last_reg;
        res_found_next = res_found_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_node_next    = m_node_reg;
        m_last_next    = m_last_reg;
        m_found_next   = m_found_reg;
        stk_ctl        = '0;
        stk_data       = root_node_reg;
        edge_set       = 1'b0;
        edge_clr       = 1'b0;
        edge_row       = in_from;
        edge_col       = in_to[LW-1:0];
        depth_we       = 1'b0;
        depth_addr     = root_node_reg;
        depth_val      = '0;

        unique case (state_reg)
            dlde_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == dlde_pkg::MODE_EDGE) begin
                        edge_set = ({1'b0, in_from} < n_eff) && ({1'b0, in_to} < n_eff);
                    end else begin
                        stk_ctl.init = 1'b1;
                        depth_we     = 1'b1;
                        state_next   = dlde_pkg::ST_POP;
                    end
                end
            end
            dlde_pkg::ST_POP: begin
                stk_ctl.pop    = 1'b1;
                node_next      = stk_top;
                res_node_next  = stk_top;
                res_found_next = 1'b0;
                res_last_next  = (cnt_after == '0);
                if (stk_top == goal_node_reg) begin
                    res_found_next = 1'b1;
                    res_last_next  = 1'b1;
                    state_next     = dlde_pkg::ST_EMIT;
                end else if (({1'b0, stk_top} < n_eff) &&
                             (next_lvl <= {1'b0, depth_limit_reg})) begin
                    lvl_next   = next_lvl[DW-1:0];
                    col_next   = '0;
                    state_next = dlde_pkg::ST_SCAN;
                end else begin
                    state_next = dlde_pkg::ST_EMIT;
                end
            end
            dlde_pkg::ST_SCAN: begin
                edge_row = node_reg;
                edge_col = col_reg;
                if (edge_reg[node_reg][col_reg]) begin
                    edge_clr     = 1'b1;
                    depth_we     = 1'b1;
                    depth_addr   = NW'(col_reg);
                    depth_val    = lvl_reg;
                    stk_ctl.push = 1'b1;
                    stk_data     = NW'(col_reg);
                end
                if ({1'b0, col_reg} == n_eff - CW'(1)) begin
                    state_next = dlde_pkg::ST_FINISH;
                end else begin
                    col_next = col_reg + LW'(1);
                end
            end
            dlde_pkg::ST_FINISH: begin
                res_last_next = (stk_count == '0);
                state_next    = dlde_pkg::ST_EMIT;
            end
            dlde_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_node_next  = res_node_reg;
                    m_last_next  = res_last_reg;
                    m_found_next = res_found_reg;
                    state_next   = res_last_reg ? dlde_pkg::ST_IDLE : dlde_pkg::ST_POP;
                end
            end
            default: begin
                state_next = dlde_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dlde_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        node_reg      <= node_next;
        col_reg       <= col_next;
        lvl_reg       <= lvl_next;
        res_node_reg  <= res_node_next;
        res_last_reg  <= res_last_next;
        res_found_reg <= res_found_next;
        m_node_reg    <= m_node_next;
        m_last_reg    <= m_last_next;
        m_found_reg   <= m_found_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < dlde_pkg::NODES; r++) begin
                edge_reg[r] <= '0;
            end
        end else if (edge_set) begin
            edge_reg[edge_row][edge_col] <= 1'b1;
        end else if (edge_clr) begin
            edge_reg[edge_row][edge_col] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (depth_we) begin
            depth_reg[depth_addr] <= depth_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg  <= CW'(dlde_pkg::NODES);
            root_node_reg   <= '0;
            goal_node_reg   <= '0;
            depth_limit_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                dlde_pkg::CFG_NODE_COUNT:  node_count_reg  <= cfg_data[CW-1:0];
                dlde_pkg::CFG_ROOT_NODE:   root_node_reg   <= cfg_data[NW-1:0];
                dlde_pkg::CFG_GOAL_NODE:   goal_node_reg   <= cfg_data[NW-1:0];
                dlde_pkg::CFG_DEPTH_LIMIT: depth_limit_reg <= cfg_data[DW-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire
